FILE: rtl/interpolated_index_table_search_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the interpolated index table search
// Concurrent assertion wrappers with and without reset masking.
// ----------------------------------------------------------------------------
`ifndef INTERPOLATED_INDEX_TABLE_SEARCH_ASSERT_SVH
`define INTERPOLATED_INDEX_TABLE_SEARCH_ASSERT_SVH

// Checked only outside reset.
`define IITS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define IITS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/iits_pkg.sv
// ----------------------------------------------------------------------------
// iits_pkg
// Shared constants and codes of the interpolated index table search.
// ----------------------------------------------------------------------------
`default_nettype none

package iits_pkg;

  localparam int DefTableDepth = 1024;
  localparam int DefKeyWidth   = 48;

  localparam int AddrFieldW  = 10;
  localparam int IndexOutW   = 10;
  localparam int StatusW     = 2;
  localparam int CfgIdxW     = 2;

  // item commands
  localparam logic CmdWrite  = 1'b0;
  localparam logic CmdLookup = 1'b1;

  // key kinds
  localparam logic KindChunk = 1'b0;
  localparam logic KindTime  = 1'b1;

  // result status codes
  localparam logic [StatusW-1:0] StatusOk       = 2'd0;
  localparam logic [StatusW-1:0] StatusNegative = 2'd1;
  localparam logic [StatusW-1:0] StatusPastEnd  = 2'd2;
  localparam logic [StatusW-1:0] StatusEmpty    = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgEntriesInUse = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTotalChunks  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTotalDur     = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/iits_if.sv
// ----------------------------------------------------------------------------
// iits_in_if / iits_out_if
// Valid/ready channels carrying command items and lookup results.
// ----------------------------------------------------------------------------
`default_nettype none

interface iits_in_if #(
  parameter int KeyWidth = iits_pkg::DefKeyWidth
);
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic [iits_pkg::AddrFieldW-1:0]   entry_address;
  logic [KeyWidth-1:0]               entry_chunk_key;
  logic [KeyWidth-1:0]               entry_time_key;
  logic signed [KeyWidth-1:0]        position;
  logic                              key_kind;

  modport source (
    output valid, cmd, entry_address, entry_chunk_key, entry_time_key, position, key_kind,
    input  ready
  );
  modport sink (
    input  valid, cmd, entry_address, entry_chunk_key, entry_time_key, position, key_kind,
    output ready
  );
endinterface

interface iits_out_if;
  logic                            valid;
  logic                            ready;
  logic [iits_pkg::IndexOutW-1:0]  found_index;
  logic [iits_pkg::StatusW-1:0]    status;

  modport source (output valid, found_index, status, input ready);
  modport sink   (input valid, found_index, status, output ready);
endinterface

`default_nettype wire

FILE: rtl/iits_ram.sv
// ----------------------------------------------------------------------------
// iits_ram
// Single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module iits_ram #(
  parameter int Width = iits_pkg::DefKeyWidth,
  parameter int Depth = iits_pkg::DefTableDepth
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/interpolated_index_table_search.sv
// Write item: accept, then the write state; the next item is taken back in idle.
// Lookup: accept, a check state, a double and an add state per bit of the entry count in the serial
//   divider, an end state, a read and a compare state per entry read (the guess and each walk step),
//   then the result state; a position equal to the total skips the divider.
// Errors found in the check state skip divider and walk; a full output register holds the result
//   back. One item in flight; reset clears state, configuration and output registers only, not tables.
// ----------------------------------------------------------------------------
// interpolated_index_table_search
// Seek table with interpolated guess and linear refinement over two key RAMs.
// ----------------------------------------------------------------------------
`default_nettype none

module interpolated_index_table_search #(
  parameter int TABLE_DEPTH = iits_pkg::DefTableDepth,
  parameter int KEY_WIDTH   = iits_pkg::DefKeyWidth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [iits_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [KEY_WIDTH-1:0]          cfg_data_i,
  iits_in_if.sink                            in_i,
  iits_out_if.source                         out_o
);

  // Widths derived from the table depth and key width
  localparam int AW      = $clog2(TABLE_DEPTH);
  localparam int CntW    = $clog2(TABLE_DEPTH + 1);
  localparam int BitW    = $clog2(CntW);
  localparam int CfgLoW  = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
  localparam int IdxExtW = (AW > iits_pkg::IndexOutW) ? AW : iits_pkg::IndexOutW;

  // Slot fold: floor(addr / TABLE_DEPTH) by reciprocal multiplication
  localparam int SlotShift = iits_pkg::AddrFieldW + $clog2(TABLE_DEPTH);
  localparam int SlotMulW  = iits_pkg::AddrFieldW + 1;
  localparam int SlotProdW = iits_pkg::AddrFieldW + SlotMulW;
  localparam logic [SlotMulW-1:0] SlotMul =
    SlotMulW'(((64'd1 << SlotShift) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH));

  typedef enum logic [3:0] {
    StIdle, StWr, StChk, StDbl, StAdd, StDivEnd,
    StFwdRd, StFwdCmp, StBwdRd, StBwdCmp, StRes
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [CntW-1:0]      count_q, count_d;
  logic [KEY_WIDTH-1:0] chunks_q, chunks_d;
  logic [KEY_WIDTH-1:0] dur_q, dur_d;

  // output register
  logic                           out_vld_q, out_vld_d;
  logic [iits_pkg::IndexOutW-1:0] out_idx_q, out_idx_d;
  logic [iits_pkg::StatusW-1:0]   out_st_q, out_st_d;

  // item payload and working registers
  logic [KEY_WIDTH-1:0]           pos_q, pos_d;
  logic                           kind_q, kind_d;
  logic [KEY_WIDTH-1:0]           wchunk_q, wchunk_d;
  logic [KEY_WIDTH-1:0]           wtime_q, wtime_d;
  logic [AW-1:0]                  rem_q, rem_d;
  logic [KEY_WIDTH-1:0]           den_q, den_d;
  logic [KEY_WIDTH-1:0]           dn_q, dn_d;
  logic [KEY_WIDTH-1:0]           r_q, r_d;
  logic [CntW-1:0]                q_q, q_d;
  logic [BitW-1:0]                bit_q, bit_d;
  logic [AW-1:0]                  idx_q, idx_d;
  logic [iits_pkg::IndexOutW-1:0] res_idx_q, res_idx_d;
  logic [iits_pkg::StatusW-1:0]   res_st_q, res_st_d;

  // RAM ports
  logic                 ram_en, ram_we;
  logic [AW-1:0]        ram_addr;
  logic [KEY_WIDTH-1:0] chunk_rdata, time_rdata, rd_key;

  // datapath terms
  logic [KEY_WIDTH-1:0]           total;
  logic [CfgLoW-1:0]              cfg_lo;
  logic [KEY_WIDTH:0]             dbl;
  logic [CntW-1:0]                last;
  logic [IdxExtW-1:0]             idx_ext;
  logic                           fwd_go, bwd_go;
  logic [SlotProdW-1:0]           slot_prod;
  logic [iits_pkg::AddrFieldW-1:0] slot_quo;
  logic [SlotProdW-1:0]           slot_rem;

  assign total   = (kind_q == iits_pkg::KindTime) ? dur_q : chunks_q;
  assign cfg_lo  = cfg_data_i[CfgLoW-1:0];
  assign dbl     = {r_q, 1'b0};
  assign last    = count_q - CntW'(1);
  assign idx_ext = IdxExtW'(idx_q);
  assign rd_key  = (kind_q == iits_pkg::KindTime) ? time_rdata : chunk_rdata;
  // Walk forward while below the position, back while above it
  assign fwd_go  = (CntW'(idx_q) < last) && (rd_key < pos_q);
  assign bwd_go  = (idx_q != '0) && (rd_key > pos_q);

  // Fold the slot address into the table: quotient by reciprocal, then subtract
  assign slot_prod = SlotProdW'(in_i.entry_address) * SlotProdW'(SlotMul);
  assign slot_quo  = iits_pkg::AddrFieldW'(slot_prod >> SlotShift);
  assign slot_rem  = SlotProdW'(in_i.entry_address)
                   - SlotProdW'(slot_quo) * SlotProdW'(TABLE_DEPTH);

  assign in_i.ready        = (state_q == StIdle);
  assign out_o.valid       = out_vld_q;
  assign out_o.found_index = out_idx_q;
  assign out_o.status      = out_st_q;

  // RAM address: folded slot for writes, walk index for reads
  always_comb begin
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    ram_addr = idx_q;
    case (state_q)
      StWr: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = rem_q;
      end
      StFwdRd, StBwdRd: begin
        ram_en = 1'b1;
      end
      default: begin
        ram_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    chunks_d  = chunks_q;
    dur_d     = dur_q;
    out_vld_d = out_vld_q;
    out_idx_d = out_idx_q;
    out_st_d  = out_st_q;
    pos_d     = pos_q;
    kind_d    = kind_q;
    wchunk_d  = wchunk_q;
    wtime_d   = wtime_q;
    rem_d     = rem_q;
    den_d     = den_q;
    dn_d      = dn_q;
    r_d       = r_q;
    q_d       = q_q;
    bit_d     = bit_q;
    idx_d     = idx_q;
    res_idx_d = res_idx_q;
    res_st_d  = res_st_q;

    // Configuration: entry count keeps its low word and saturates at the depth
    if (cfg_we_i) begin
      case (cfg_idx_i)
        iits_pkg::CfgEntriesInUse: begin
          if (33'(cfg_lo) > 33'(TABLE_DEPTH)) begin
            count_d = CntW'(TABLE_DEPTH);
          end else begin
            count_d = CntW'(cfg_lo);
          end
        end
        iits_pkg::CfgTotalChunks: chunks_d = cfg_data_i;
        iits_pkg::CfgTotalDur:    dur_d    = cfg_data_i;
        default: ;
      endcase
    end

    // Drop the result once the sink takes it
    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_i.valid) begin
          if (in_i.cmd == iits_pkg::CmdWrite) begin
            rem_d    = AW'(slot_rem);
            wchunk_d = in_i.entry_chunk_key;
            wtime_d  = in_i.entry_time_key;
            state_d  = StWr;
          end else begin
            pos_d   = in_i.position;
            kind_d  = in_i.key_kind;
            state_d = StChk;
          end
        end
      end

      StWr: begin
        state_d = StIdle;
      end

      StChk: begin
        res_idx_d = '0;
        if (pos_q[KEY_WIDTH-1]) begin
          res_st_d = iits_pkg::StatusNegative;
          state_d  = StRes;
        end else if (total == '0) begin
          res_st_d = iits_pkg::StatusEmpty;
          state_d  = StRes;
        end else if ((count_q == '0) || (pos_q > total)) begin
          res_st_d = iits_pkg::StatusPastEnd;
          state_d  = StRes;
        end else if (pos_q == total) begin
          // position at the total starts the walk at the last entry in use
          idx_d   = AW'(last);
          state_d = StFwdRd;
        end else begin
          den_d   = total;
          dn_d    = total - pos_q;
          r_d     = '0;
          q_d     = '0;
          bit_d   = BitW'(CntW - 1);
          state_d = StDbl;
        end
      end

      // Serial divider: floor(pos * count / total), remainder kept below total
      StDbl: begin
        if (dbl >= {1'b0, den_q}) begin
          r_d = KEY_WIDTH'(dbl - {1'b0, den_q});
          q_d = {q_q[CntW-2:0], 1'b1};
        end else begin
          r_d = dbl[KEY_WIDTH-1:0];
          q_d = {q_q[CntW-2:0], 1'b0};
        end
        state_d = StAdd;
      end

      StAdd: begin
        if (count_q[bit_q]) begin
          if (r_q >= dn_q) begin
            r_d = r_q - dn_q;
            q_d = q_q + CntW'(1);
          end else begin
            r_d = r_q + pos_q;
          end
        end
        if (bit_q == '0) begin
          state_d = StDivEnd;
        end else begin
          bit_d   = bit_q - BitW'(1);
          state_d = StDbl;
        end
      end

      StDivEnd: begin
        if (q_q >= count_q) begin
          res_idx_d = '0;
          res_st_d  = iits_pkg::StatusPastEnd;
          state_d   = StRes;
        end else begin
          idx_d   = AW'(q_q);
          state_d = StFwdRd;
        end
      end

      StFwdRd: state_d = StFwdCmp;

      StFwdCmp: begin
        if (fwd_go) begin
          idx_d   = idx_q + AW'(1);
          state_d = StFwdRd;
        end else if (bwd_go) begin
          idx_d   = idx_q - AW'(1);
          state_d = StBwdRd;
        end else begin
          res_idx_d = idx_ext[iits_pkg::IndexOutW-1:0];
          res_st_d  = iits_pkg::StatusOk;
          state_d   = StRes;
        end
      end

      StBwdRd: state_d = StBwdCmp;

      StBwdCmp: begin
        if (bwd_go) begin
          idx_d   = idx_q - AW'(1);
          state_d = StBwdRd;
        end else begin
          res_idx_d = idx_ext[iits_pkg::IndexOutW-1:0];
          res_st_d  = iits_pkg::StatusOk;
          state_d   = StRes;
        end
      end

      // Hold the result until the output register is free
      StRes: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d = 1'b1;
          out_idx_d = res_idx_q;
          out_st_d  = res_st_q;
          state_d   = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      count_q   <= '0;
      chunks_q  <= '0;
      dur_q     <= '0;
      out_vld_q <= 1'b0;
      out_idx_q <= '0;
      out_st_q  <= iits_pkg::StatusOk;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      chunks_q  <= chunks_d;
      dur_q     <= dur_d;
      out_vld_q <= out_vld_d;
      out_idx_q <= out_idx_d;
      out_st_q  <= out_st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    kind_q    <= kind_d;
    wchunk_q  <= wchunk_d;
    wtime_q   <= wtime_d;
    rem_q     <= rem_d;
    den_q     <= den_d;
    dn_q      <= dn_d;
    r_q       <= r_d;
    q_q       <= q_d;
    bit_q     <= bit_d;
    idx_q     <= idx_d;
    res_idx_q <= res_idx_d;
    res_st_q  <= res_st_d;
  end

  iits_ram #(
    .Width (KEY_WIDTH),
    .Depth (TABLE_DEPTH)
  ) u_chunk_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (wchunk_q),
    .rdata_o (chunk_rdata)
  );

  iits_ram #(
    .Width (KEY_WIDTH),
    .Depth (TABLE_DEPTH)
  ) u_time_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (wtime_q),
    .rdata_o (time_rdata)
  );

endmodule

`default_nettype wire

FILE: rtl/iits_checker.sv
// ----------------------------------------------------------------------------
// iits_checker
// Port-level checks on the interpolated index table search.
// ----------------------------------------------------------------------------
`default_nettype none

`include "interpolated_index_table_search_assert.svh"

module iits_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_i,
  input wire logic                           out_valid_i,
  input wire logic                           out_ready_i,
  input wire logic [iits_pkg::IndexOutW-1:0] found_index_i,
  input wire logic [iits_pkg::StatusW-1:0]   status_i
);

  `IITS_ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |-> !out_valid_i, "result during reset")
  `IITS_ASSERT(a_result_held, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped")
  `IITS_ASSERT(a_index_zero_on_error, clk_i, rst_ni, out_valid_i && (status_i != iits_pkg::StatusOk) |-> found_index_i == '0, "index not zero")
  `IITS_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i |=> !in_ready_i, "ready after item")

endmodule

bind interpolated_index_table_search iits_checker u_iits_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .found_index_i (out_o.found_index),
  .status_i      (out_o.status)
);

`default_nettype wire
